// ===== rtl/core/dsplc_pkg.sv =====
`default_nettype none
package dsplc_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

	typedef logic [TIMER_WIDTH-1:0] timer_t;
	typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
	typedef logic [2:0]             lamp_t;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_AUTO      = 2'd1,
		MODE_AUTO_STOP = 2'd2,
		MODE_ERROR     = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic REG_BLINK_PERIOD   = 1'b0;
	localparam logic REG_BUZZER_TIMEOUT = 1'b1;

	localparam cfg_word_t BLINK_PERIOD_RST   = CFG_WIDTH'(50);
	localparam cfg_word_t BUZZER_TIMEOUT_RST = CFG_WIDTH'(3000);

	// lamp bit patterns: bit0 green, bit1 red, bit2 yellow
	localparam lamp_t LAMP_GREEN = 3'b001;
	localparam lamp_t LAMP_RED   = 3'b010;
	localparam lamp_t LAMP_ALL   = 3'b111;

	typedef struct packed {
		mode_t  mode;
		logic   init;
		logic   held;
		logic   phase;
		logic   silenced;
		timer_t timer;
	} side_in_t;

	typedef struct packed {
		lamp_t  lamp;
		lamp_t  tower;
		logic   phase;
		timer_t timer;
	} side_out_t;

	function automatic logic timer_expired(timer_t t, cfg_word_t interval);
		return CMP_WIDTH'(t) >= CMP_WIDTH'(interval);
	endfunction

	// restart to zero, otherwise count up and stick at the top
	function automatic timer_t timer_next(timer_t t, logic restart);
		if (restart) begin
			return '0;
		end else if (t != {TIMER_WIDTH{1'b1}}) begin
			return t + TIMER_WIDTH'(1);
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dsplc_side_lamps.sv =====
`default_nettype none
module dsplc_side_lamps (
	input  wire dsplc_pkg::side_in_t  side_in,
	input  wire dsplc_pkg::cfg_word_t blink_period,
	output dsplc_pkg::side_out_t      side_out
);

	logic blinking;
	logic restart;
	logic p;

	always_comb begin
		p        = side_in.phase;
		blinking = 1'b1;
		restart  = 1'b0;
		side_out.phase = side_in.phase;
		if (side_in.mode == dsplc_pkg::MODE_ERROR) begin
			side_out.lamp  = {~side_in.silenced, p, 1'b0};
			side_out.tower = {1'b0, p, 1'b0};
		end else if (side_in.mode == dsplc_pkg::MODE_AUTO && side_in.init) begin
			side_out.lamp  = {2'b00, p};
			side_out.tower = {2'b00, p};
		end else if (side_in.mode == dsplc_pkg::MODE_AUTO && side_in.held) begin
			side_out.lamp  = {p, 2'b01};
			side_out.tower = {p, 2'b01};
		end else begin
			// steady lamps: park phase high and restart the blink timer
			blinking       = 1'b0;
			restart        = 1'b1;
			side_out.phase = 1'b1;
			if (side_in.mode == dsplc_pkg::MODE_IDLE) begin
				side_out.lamp = dsplc_pkg::LAMP_ALL;
			end else if (side_in.mode == dsplc_pkg::MODE_AUTO) begin
				side_out.lamp = dsplc_pkg::LAMP_GREEN;
			end else begin
				side_out.lamp = dsplc_pkg::LAMP_RED;
			end
			side_out.tower = side_out.lamp;
		end
		if (blinking && dsplc_pkg::timer_expired(side_in.timer, blink_period)) begin
			side_out.phase = ~p;
			restart        = 1'b1;
		end
		side_out.timer = dsplc_pkg::timer_next(side_in.timer, restart);
	end

endmodule
`default_nettype wire

// ===== rtl/core/dual_station_panel_lamp_controller_top.sv =====
`default_nettype none
// Panel lamp controller for two stations, one poll tick per input word.
// A held word moves into the result register, with out_valid high, when that register is free or draining.
// Throughput: one word per cycle while out_stall is low; input and result registers hold one word each.
// All tick logic is one combinational pass from the input register to the result register.
// Reset (arst_n low, asynchronous): both modes idle, phases high, buzzer not silenced,
// timers zero, registers back to blink_period 50 and buzzer_timeout 3000, no word held.
module dual_station_panel_lamp_controller_top (
	input  wire        clk,
	input  wire        arst_n,
	// configuration
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [15:0] cfg_wdata,
	// input channel
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        left_start,
	input  wire        left_stop,
	input  wire        left_reset,
	input  wire        right_start,
	input  wire        right_stop,
	input  wire        right_reset,
	input  wire        master_fault,
	input  wire        left_initializing,
	input  wire        right_initializing,
	input  wire [5:0]  left_held_lines,
	input  wire [5:0]  right_held_lines,
	// output channel
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] left_lamp_bits,
	output logic [2:0] left_tower_bits,
	output logic [2:0] right_lamp_bits,
	output logic [2:0] right_tower_bits,
	output logic       buzzer_on,
	output logic       master_start_pulse,
	output logic       master_stop_pulse,
	output logic [1:0] left_mode_out,
	output logic [1:0] right_mode_out
);

	typedef struct packed {
		logic       l_start;
		logic       l_stop;
		logic       l_reset;
		logic       r_start;
		logic       r_stop;
		logic       r_reset;
		logic       fault;
		logic       l_init;
		logic       r_init;
		logic [5:0] l_held;
		logic [5:0] r_held;
	} tick_t;

	typedef struct packed {
		logic [2:0]       l_lamp;
		logic [2:0]       l_tower;
		logic [2:0]       r_lamp;
		logic [2:0]       r_tower;
		logic             buzz;
		logic             start_pulse;
		logic             stop_pulse;
		dsplc_pkg::mode_t l_mode;
		dsplc_pkg::mode_t r_mode;
	} result_t;

	// configuration registers
	dsplc_pkg::cfg_word_t blink_period_q;
	dsplc_pkg::cfg_word_t buzzer_timeout_q;

	// input stage
	logic  valid_s1;
	tick_t tick_s1;

	// tick state
	dsplc_pkg::mode_t  left_mode_q;
	dsplc_pkg::mode_t  right_mode_q;
	logic              left_phase_q;
	logic              right_phase_q;
	logic              buzzer_phase_q;
	logic              buzzer_silenced_q;
	dsplc_pkg::timer_t left_blink_ticks_q;
	dsplc_pkg::timer_t right_blink_ticks_q;
	dsplc_pkg::timer_t buzzer_blink_ticks_q;
	dsplc_pkg::timer_t buzzer_timeout_ticks_q;

	// result stage
	logic    out_valid_q;
	result_t result_q;

	logic advance;
	logic in_accept;

	// next-state values from the combinational pass
	dsplc_pkg::mode_t    lm_sw, rm_sw;
	logic                sil_sw;
	logic                start_p, stop_p;
	logic                any_err;
	logic                buzz;
	logic                bz_phase_nx;
	logic                bz_sil_nx;
	logic                bz_blink_rst;
	logic                bz_timeout_rst;
	dsplc_pkg::side_in_t  l_side_in, r_side_in;
	dsplc_pkg::side_out_t l_side_out, r_side_out;
	result_t             result_nx;

	// move the held word into the result register when that register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q   <= dsplc_pkg::BLINK_PERIOD_RST;
			buzzer_timeout_q <= dsplc_pkg::BUZZER_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsplc_pkg::REG_BLINK_PERIOD:   blink_period_q   <= cfg_wdata;
				dsplc_pkg::REG_BUZZER_TIMEOUT: buzzer_timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register: payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tick_s1 <= '{l_start: left_start, l_stop: left_stop, l_reset: left_reset,
				r_start: right_start, r_stop: right_stop, r_reset: right_reset,
				fault: master_fault, l_init: left_initializing,
				r_init: right_initializing, l_held: left_held_lines,
				r_held: right_held_lines};
		end
	end

	// switches: left first, so the right stop sees the left mode already updated
	always_comb begin
		lm_sw   = left_mode_q;
		rm_sw   = right_mode_q;
		sil_sw  = buzzer_silenced_q;
		start_p = 1'b0;
		stop_p  = 1'b0;
		if (tick_s1.l_start) begin
			if (left_mode_q != dsplc_pkg::MODE_AUTO) begin
				lm_sw   = dsplc_pkg::MODE_AUTO;
				start_p = 1'b1;
			end
		end else if (tick_s1.l_stop) begin
			lm_sw = dsplc_pkg::MODE_AUTO_STOP;
			if (right_mode_q != dsplc_pkg::MODE_AUTO) begin
				stop_p = 1'b1;
			end
		end else if (tick_s1.l_reset && left_mode_q == dsplc_pkg::MODE_ERROR) begin
			sil_sw = 1'b1;
		end
		if (tick_s1.r_start) begin
			if (right_mode_q != dsplc_pkg::MODE_AUTO) begin
				rm_sw   = dsplc_pkg::MODE_AUTO;
				start_p = 1'b1;
			end
		end else if (tick_s1.r_stop) begin
			rm_sw = dsplc_pkg::MODE_AUTO_STOP;
			if (lm_sw != dsplc_pkg::MODE_AUTO) begin
				stop_p = 1'b1;
			end
		end else if (tick_s1.r_reset && right_mode_q == dsplc_pkg::MODE_ERROR) begin
			sil_sw = 1'b1;
		end
	end

	assign l_side_in = '{mode: lm_sw, init: tick_s1.l_init, held: |tick_s1.l_held,
		phase: left_phase_q, silenced: sil_sw, timer: left_blink_ticks_q};
	assign r_side_in = '{mode: rm_sw, init: tick_s1.r_init, held: |tick_s1.r_held,
		phase: right_phase_q, silenced: sil_sw, timer: right_blink_ticks_q};

	dsplc_side_lamps u_left_lamps (
		.side_in      (l_side_in),
		.blink_period (blink_period_q),
		.side_out     (l_side_out)
	);

	dsplc_side_lamps u_right_lamps (
		.side_in      (r_side_in),
		.blink_period (blink_period_q),
		.side_out     (r_side_out)
	);

	// buzzer: blink while either side is in error, drop after the timeout
	assign any_err = (lm_sw == dsplc_pkg::MODE_ERROR) || (rm_sw == dsplc_pkg::MODE_ERROR);

	always_comb begin
		buzz           = 1'b0;
		bz_phase_nx    = buzzer_phase_q;
		bz_sil_nx      = sil_sw;
		bz_blink_rst   = 1'b0;
		bz_timeout_rst = 1'b0;
		if (any_err) begin
			if (dsplc_pkg::timer_expired(buzzer_timeout_ticks_q, buzzer_timeout_q)) begin
				bz_sil_nx = 1'b1;
			end else begin
				buzz = buzzer_phase_q && !sil_sw;
				if (dsplc_pkg::timer_expired(buzzer_blink_ticks_q, blink_period_q)) begin
					bz_phase_nx  = ~buzzer_phase_q;
					bz_blink_rst = 1'b1;
				end
			end
		end else begin
			bz_phase_nx    = 1'b1;
			bz_sil_nx      = 1'b0;
			bz_blink_rst   = 1'b1;
			bz_timeout_rst = 1'b1;
		end
	end

	// master error overrides both modes last
	always_comb begin
		result_nx.l_lamp      = l_side_out.lamp;
		result_nx.l_tower     = l_side_out.tower;
		result_nx.r_lamp      = r_side_out.lamp;
		result_nx.r_tower     = r_side_out.tower;
		result_nx.buzz        = buzz;
		result_nx.start_pulse = start_p;
		result_nx.stop_pulse  = stop_p;
		result_nx.l_mode      = tick_s1.fault ? dsplc_pkg::MODE_ERROR : lm_sw;
		result_nx.r_mode      = tick_s1.fault ? dsplc_pkg::MODE_ERROR : rm_sw;
	end

	// commit tick state when the word moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mode_q            <= dsplc_pkg::MODE_IDLE;
			right_mode_q           <= dsplc_pkg::MODE_IDLE;
			left_phase_q           <= 1'b1;
			right_phase_q          <= 1'b1;
			buzzer_phase_q         <= 1'b1;
			buzzer_silenced_q      <= 1'b0;
			left_blink_ticks_q     <= '0;
			right_blink_ticks_q    <= '0;
			buzzer_blink_ticks_q   <= '0;
			buzzer_timeout_ticks_q <= '0;
		end else if (advance) begin
			left_mode_q            <= result_nx.l_mode;
			right_mode_q           <= result_nx.r_mode;
			left_phase_q           <= l_side_out.phase;
			right_phase_q          <= r_side_out.phase;
			buzzer_phase_q         <= bz_phase_nx;
			buzzer_silenced_q      <= bz_sil_nx;
			left_blink_ticks_q     <= l_side_out.timer;
			right_blink_ticks_q    <= r_side_out.timer;
			buzzer_blink_ticks_q   <= dsplc_pkg::timer_next(buzzer_blink_ticks_q, bz_blink_rst);
			buzzer_timeout_ticks_q <= dsplc_pkg::timer_next(buzzer_timeout_ticks_q,
				bz_timeout_rst);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nx;
		end
	end

	assign out_valid          = out_valid_q;
	assign left_lamp_bits     = result_q.l_lamp;
	assign left_tower_bits    = result_q.l_tower;
	assign right_lamp_bits    = result_q.r_lamp;
	assign right_tower_bits   = result_q.r_tower;
	assign buzzer_on          = result_q.buzz;
	assign master_start_pulse = result_q.start_pulse;
	assign master_stop_pulse  = result_q.stop_pulse;
	assign left_mode_out      = result_q.l_mode;
	assign right_mode_out     = result_q.r_mode;

	// a processed master error leaves both sides in error
	a_fault_forces_error: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tick_s1.fault |=>
		left_mode_q == dsplc_pkg::MODE_ERROR && right_mode_q == dsplc_pkg::MODE_ERROR)
		else $error("master error did not force both modes to error");

	// state only moves with a word
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(left_blink_ticks_q) && $stable(buzzer_timeout_ticks_q)
		&& $stable(left_mode_q) && $stable(right_mode_q))
		else $error("tick state changed without a word");

	// the buzzer sounds only with a side in error
	a_buzz_needs_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.buzz |->
		result_q.l_mode == dsplc_pkg::MODE_ERROR || result_q.r_mode == dsplc_pkg::MODE_ERROR)
		else $error("buzzer on with no side in error");

	// output mode ports track the committed modes
	a_mode_out_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_q.l_mode == left_mode_q && result_q.r_mode == right_mode_q)
		else $error("reported modes differ from the state");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import dsplc_pkg::*;

	// Give up after this many clock cycles.
	localparam int CYCLE_LIMIT = 1_500_000;
	// Words through the output before the receiver goes quiet for a long stretch.
	localparam int HOLD_AFTER_WORDS = 400;
	localparam int HOLD_CYCLES = 200;

	// One poll tick. Index 0 of every pair is the left station, index 1 the right one.
	typedef struct packed {
		logic [1:0]      start;
		logic [1:0]      stop;
		logic [1:0]      reset_sw;
		logic            fault;
		logic [1:0]      init;
		logic [1:0][5:0] held;
	} poll_tick_t;

	// What the panel shows after one tick.
	typedef struct packed {
		lamp_t [1:0]     lamp;
		lamp_t [1:0]     tower;
		logic            buzz;
		logic            start_pulse;
		logic            stop_pulse;
		logic [1:0][1:0] mode;
	} panel_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Configuration port, driven from the sequencing block only.
	logic      cfg_we = 1'b0;
	logic      cfg_index = REG_BLINK_PERIOD;
	cfg_word_t cfg_wdata = '0;

	// Input channel.
	logic       in_valid = 1'b0;
	logic       in_stall;
	poll_tick_t bus_tick = '0;

	// Output channel.
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] left_lamp_bits;
	logic [2:0] left_tower_bits;
	logic [2:0] right_lamp_bits;
	logic [2:0] right_tower_bits;
	logic       buzzer_on;
	logic       master_start_pulse;
	logic       master_stop_pulse;
	logic [1:0] left_mode_out;
	logic [1:0] right_mode_out;

	// Ticks waiting to be offered, and panel words the block still owes us.
	poll_tick_t  tick_q[$];
	panel_word_t lamp_expect_q[$];

	// Our own copy of the controller state and its two registers.
	mode_t     side_mode [2];
	logic      side_phase [2];
	timer_t    side_ticks [2];
	logic      buzz_phase;
	logic      buzz_quiet;
	timer_t    buzz_ticks;
	timer_t    buzz_age;
	cfg_word_t blink_period;
	cfg_word_t buzz_limit;

	// Idling switches, set per phase while the block is empty.
	logic sender_idles = 1'b1;
	logic receiver_idles = 1'b1;

	int unsigned mismatches = 0;
	int unsigned words_checked = 0;
	int unsigned cycles = 0;
	int          gap_left = 0;
	int          stall_run = 0;
	int          hold_cycles = 0;
	logic        hold_done = 1'b0;
	logic        hold_off = 1'b0;
	panel_word_t want;

	dual_station_panel_lamp_controller_top uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.left_start         (bus_tick.start[0]),
		.left_stop          (bus_tick.stop[0]),
		.left_reset         (bus_tick.reset_sw[0]),
		.right_start        (bus_tick.start[1]),
		.right_stop         (bus_tick.stop[1]),
		.right_reset        (bus_tick.reset_sw[1]),
		.master_fault       (bus_tick.fault),
		.left_initializing  (bus_tick.init[0]),
		.right_initializing (bus_tick.init[1]),
		.left_held_lines    (bus_tick.held[0]),
		.right_held_lines   (bus_tick.held[1]),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.left_lamp_bits     (left_lamp_bits),
		.left_tower_bits    (left_tower_bits),
		.right_lamp_bits    (right_lamp_bits),
		.right_tower_bits   (right_tower_bits),
		.buzzer_on          (buzzer_on),
		.master_start_pulse (master_start_pulse),
		.master_stop_pulse  (master_stop_pulse),
		.left_mode_out      (left_mode_out),
		.right_mode_out     (right_mode_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance a tick timer: back to zero on restart, else count up and stick at the top.
	function automatic timer_t count_tick(timer_t t, logic restart);
		if (restart) begin
			return '0;
		end
		return (t == '1) ? t : t + 1'b1;
	endfunction

	// Mostly back-to-back, sometimes a short gap, now and then a long pause.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(3, 1);
		end else if (r < 97) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	function automatic poll_tick_t tick_of(logic [1:0] start, logic [1:0] stop,
			logic [1:0] reset_sw, logic fault, logic [1:0] init,
			logic [5:0] held_l, logic [5:0] held_r);
		poll_tick_t t;
		t.start = start;
		t.stop = stop;
		t.reset_sw = reset_sw;
		t.fault = fault;
		t.init = init;
		t.held[0] = held_l;
		t.held[1] = held_r;
		return t;
	endfunction

	// Random tick: each switch pressed about once in 'odds' ticks, the master
	// fault half as often, held lines clear half the time.
	function automatic poll_tick_t rand_tick(int unsigned odds);
		poll_tick_t t;
		for (int s = 0; s < 2; s++) begin
			t.start[s] = ($urandom_range(odds - 1) == 0);
			t.stop[s] = ($urandom_range(odds - 1) == 0);
			t.reset_sw[s] = ($urandom_range(odds - 1) == 0);
			t.init[s] = ($urandom_range(2) == 0);
			case ($urandom_range(3))
				0, 1: begin
					t.held[s] = '0;
				end
				2: begin
					t.held[s] = 6'd1 << $urandom_range(5);
				end
				default: begin
					t.held[s] = 6'($urandom);
				end
			endcase
		end
		t.fault = ($urandom_range(2 * odds - 1) == 0);
		return t;
	endfunction

	// Run one poll tick through our copy of the controller and return the panel word.
	function automatic panel_word_t predict_panel(poll_tick_t t);
		panel_word_t w;
		logic        p;
		logic        blinking;
		logic        restart;
		logic        buzz_blink_restart;
		logic        buzz_age_restart;
		int          o;

		w = '0;
		buzz_blink_restart = 1'b0;
		buzz_age_restart = 1'b0;

		// Switches, left first: start beats stop, stop beats reset.
		for (int s = 0; s < 2; s++) begin
			o = 1 - s;
			if (t.start[s]) begin
				if (side_mode[s] != MODE_AUTO) begin
					side_mode[s] = MODE_AUTO;
					w.start_pulse = 1'b1;
				end
			end else if (t.stop[s]) begin
				side_mode[s] = MODE_AUTO_STOP;
				if (side_mode[o] != MODE_AUTO) begin
					w.stop_pulse = 1'b1;
				end
			end else if (t.reset_sw[s] && side_mode[s] == MODE_ERROR) begin
				buzz_quiet = 1'b1;
			end
		end

		// Lamps and tower, left then right.
		for (int s = 0; s < 2; s++) begin
			p = side_phase[s];
			blinking = 1'b1;
			restart = 1'b0;
			if (side_mode[s] == MODE_ERROR) begin
				w.lamp[s] = {!buzz_quiet, p, 1'b0};
				w.tower[s] = {1'b0, p, 1'b0};
			end else if (side_mode[s] == MODE_AUTO && t.init[s]) begin
				w.lamp[s] = {2'b00, p};
				w.tower[s] = w.lamp[s];
			end else if (side_mode[s] == MODE_AUTO && |t.held[s]) begin
				w.lamp[s] = {p, 1'b0, 1'b1};
				w.tower[s] = w.lamp[s];
			end else begin
				blinking = 1'b0;
				side_phase[s] = 1'b1;
				restart = 1'b1;
				if (side_mode[s] == MODE_IDLE) begin
					w.lamp[s] = LAMP_ALL;
				end else if (side_mode[s] == MODE_AUTO) begin
					w.lamp[s] = LAMP_GREEN;
				end else begin
					w.lamp[s] = LAMP_RED;
				end
				w.tower[s] = w.lamp[s];
			end
			if (blinking && side_ticks[s] >= blink_period) begin
				side_phase[s] = !side_phase[s];
				restart = 1'b1;
			end
			side_ticks[s] = count_tick(side_ticks[s], restart);
		end

		// Buzzer: blinks while either side is in error, until it times out or is silenced.
		if (side_mode[0] == MODE_ERROR || side_mode[1] == MODE_ERROR) begin
			if (buzz_age >= buzz_limit) begin
				buzz_quiet = 1'b1;
				w.buzz = 1'b0;
			end else begin
				w.buzz = buzz_phase && !buzz_quiet;
				if (buzz_ticks >= blink_period) begin
					buzz_phase = !buzz_phase;
					buzz_blink_restart = 1'b1;
				end
			end
		end else begin
			w.buzz = 1'b0;
			buzz_phase = 1'b1;
			buzz_quiet = 1'b0;
			buzz_blink_restart = 1'b1;
			buzz_age_restart = 1'b1;
		end
		buzz_ticks = count_tick(buzz_ticks, buzz_blink_restart);
		buzz_age = count_tick(buzz_age, buzz_age_restart);

		// Master fault comes last and overrides both modes.
		if (t.fault) begin
			side_mode[0] = MODE_ERROR;
			side_mode[1] = MODE_ERROR;
		end
		w.mode[0] = side_mode[0];
		w.mode[1] = side_mode[1];
		return w;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
			input int unsigned got_val);
		if (exp_val != got_val) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("word %0d %s: expected %0d, got %0d", words_checked, name,
					exp_val, got_val);
			end
		end
	endtask

	// Write one register while the block is empty, and mirror it in our copy.
	task automatic write_reg(input logic idx, input cfg_word_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BLINK_PERIOD) begin
			blink_period = val;
		end else begin
			buzz_limit = val;
		end
	endtask

	// Wait until every tick is sent and every panel word is back, then let the block settle.
	task automatic drain();
		@(negedge clk);
		while (tick_q.size() != 0 || in_valid || lamp_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Sender: take the next tick from the queue whenever the channel is free,
	// hold it steady while stalled, and predict its panel word once accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				lamp_expect_q.push_back(predict_panel(bus_tick));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					bus_tick <= tick_q.pop_front();
					in_valid <= 1'b1;
					gap_left = sender_idles ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off: once enough words have come out, refuse everything for a
	// while so the block fills up and pushes back on the sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 1'b0;
			hold_cycles = 0;
		end else begin
			if (!hold_done && words_checked >= HOLD_AFTER_WORDS) begin
				hold_done = 1'b1;
				hold_cycles = HOLD_CYCLES;
			end
			hold_off <= (hold_cycles != 0);
			if (hold_cycles != 0) begin
				hold_cycles--;
			end
		end
	end

	// Receiver: stall in random runs on top of the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_run = 0;
		end else begin
			if (stall_run == 0 && receiver_idles && $urandom_range(5) == 0) begin
				stall_run = pick_gap();
			end
			out_stall <= hold_off || (stall_run != 0);
			if (stall_run != 0) begin
				stall_run--;
			end
		end
	end

	// Checker: every accepted panel word must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			words_checked++;
			if (lamp_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("word %0d arrived with no tick pending", words_checked);
				end
			end else begin
				want = lamp_expect_q.pop_front();
				check_field("left_lamp_bits", want.lamp[0], left_lamp_bits);
				check_field("left_tower_bits", want.tower[0], left_tower_bits);
				check_field("right_lamp_bits", want.lamp[1], right_lamp_bits);
				check_field("right_tower_bits", want.tower[1], right_tower_bits);
				check_field("buzzer_on", want.buzz, buzzer_on);
				check_field("master_start_pulse", want.start_pulse, master_start_pulse);
				check_field("master_stop_pulse", want.stop_pulse, master_stop_pulse);
				check_field("left_mode_out", want.mode[0], left_mode_out);
				check_field("right_mode_out", want.mode[1], right_mode_out);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		cfg_word_t   phase_period [7];
		cfg_word_t   phase_limit [7];
		int unsigned phase_odds [7];
		int unsigned phase_ticks [7];

		// Blink period, buzzer timeout, switch odds and tick count per random phase.
		phase_period = '{16'd1, 16'd3, 16'd65535, 16'd2, 16'd7, 16'd0, 16'd50};
		phase_limit = '{16'd1, 16'd20, 16'd0, 16'd65535, 16'd100, 16'd5, 16'd3000};
		phase_odds = '{6, 30, 20, 40, 60, 15, 25};
		phase_ticks = '{150, 200, 150, 150, 200, 100, 150};

		// State after reset.
		side_mode[0] = MODE_IDLE;
		side_mode[1] = MODE_IDLE;
		side_phase[0] = 1'b1;
		side_phase[1] = 1'b1;
		side_ticks[0] = '0;
		side_ticks[1] = '0;
		buzz_phase = 1'b1;
		buzz_quiet = 1'b0;
		buzz_ticks = '0;
		buzz_age = '0;
		blink_period = BLINK_PERIOD_RST;
		buzz_limit = BUZZER_TIMEOUT_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk with the reset register values.
		// Idle panel, with and without held lines and initializing units.
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b11, 6'h3F, 6'h3F));
		// Left start, then start again while already in auto: no second pulse.
		tick_q.push_back(tick_of(2'b01, 2'b00, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b01, 2'b00, 2'b00, 1'b0, 2'b01, 6'h00, 6'h00));
		// Auto with held lines, all of them and a single one.
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b00, 6'h3F, 6'h00));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b00, 6'h20, 6'h01));
		// Right stop while left runs: no stop pulse.
		tick_q.push_back(tick_of(2'b00, 2'b10, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		// All right switches at once: start wins.
		tick_q.push_back(tick_of(2'b10, 2'b10, 2'b10, 1'b0, 2'b00, 6'h00, 6'h00));
		// Stop plus reset on both sides: stop wins, right sees left already stopped.
		tick_q.push_back(tick_of(2'b00, 2'b11, 2'b11, 1'b0, 2'b00, 6'h00, 6'h00));
		// Reset outside error does nothing.
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b11, 1'b0, 2'b00, 6'h00, 6'h00));
		// Master fault drives both sides into error; sit there a tick.
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b1, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b11, 6'h15, 6'h2A));
		// Left reset in error silences the buzzer.
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b01, 1'b0, 2'b00, 6'h00, 6'h00));
		// Start on both with the fault still there: auto, then error again.
		tick_q.push_back(tick_of(2'b11, 2'b00, 2'b00, 1'b1, 2'b00, 6'h00, 6'h00));
		// Right back to auto while left stays in error.
		tick_q.push_back(tick_of(2'b10, 2'b00, 2'b00, 1'b0, 2'b10, 6'h00, 6'h00));
		// Left stop with right in auto: no pulse; then right stop: pulse.
		tick_q.push_back(tick_of(2'b00, 2'b01, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b00, 2'b10, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		// Everything at once.
		tick_q.push_back(tick_of(2'b11, 2'b11, 2'b11, 1'b1, 2'b11, 6'h3F, 6'h3F));
		drain();

		// Zero blink period and zero buzzer timeout: toggle every tick, silent at once.
		write_reg(REG_BLINK_PERIOD, 16'd0);
		write_reg(REG_BUZZER_TIMEOUT, 16'd0);
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b1, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(tick_of(2'b11, 2'b00, 2'b00, 1'b0, 2'b01, 6'h00, 6'h3F));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b01, 6'h00, 6'h3F));
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b0, 2'b01, 6'h00, 6'h3F));
		drain();

		// Random phases, each with its own registers, switch density and idling mix.
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_BLINK_PERIOD, phase_period[ph]);
			write_reg(REG_BUZZER_TIMEOUT, phase_limit[ph]);
			sender_idles = ($urandom_range(3) != 0);
			receiver_idles = ($urandom_range(3) != 0);
			for (int n = 0; n < phase_ticks[ph]; n++) begin
				tick_q.push_back(rand_tick(phase_odds[ph]));
			end
			drain();
		end

		// Short soak in error with the widest blink period and a modest buzzer timeout:
		// the lamps hold their phase while the buzzer times out and silences itself.
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		write_reg(REG_BLINK_PERIOD, 16'hFFFF);
		write_reg(REG_BUZZER_TIMEOUT, 16'd30);
		tick_q.push_back(tick_of(2'b00, 2'b00, 2'b00, 1'b1, 2'b00, 6'h00, 6'h00));
		for (int n = 0; n < 40; n++) begin
			tick_q.push_back('0);
		end
		tick_q.push_back(tick_of(2'b11, 2'b00, 2'b00, 1'b0, 2'b00, 6'h00, 6'h00));
		tick_q.push_back(rand_tick(4));
		drain();

		if (mismatches == 0 && lamp_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
